/* design/svng_pkg.sv */
// Shared constants, types and functions for the smooth vertex normal generator.
package svng_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int AW           = $clog2(MAX_VERTICES);
  localparam int CW           = AW + 1;
  localparam int POS_W        = 32;
  localparam int NRM_W        = 16;
  localparam int SUM_W        = 32;
  localparam int MAG_W        = 63;
  localparam int EDG_W        = POS_W + 1;
  localparam int LEN_W        = 31;
  localparam int QUO_W        = 16;
  localparam int FRAC_W       = 14;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } norm_req_t;

  typedef struct packed {
    logic                  done;
    logic [2:0][NRM_W-1:0] nrm;
  } norm_rsp_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                              input logic [NRM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W-NRM_W+1){b[NRM_W-1]}}, b});
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

/* design/svng_in_if.sv */
// Request channel carrying one opcode item.
interface svng_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [11:0]        vertex_slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [11:0]        corner_a;
  logic [11:0]        corner_b;
  logic [11:0]        corner_c;

  modport source (output valid, opcode, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, opcode, vertex_slot, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

/* design/svng_out_if.sv */
// Result channel carrying status and a Q2.14 normal.
interface svng_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  modport source (output valid, status, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, status, norm_x, norm_y, norm_z, output ready);
endinterface

/* design/svng_ram.sv */
// Generic single write port, single registered read port RAM.
module svng_ram #(
  parameter int DW = 96,
  parameter int AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/svng_norm.sv */
// Iterative vector normalizer: range shift, sum of squares, root, divides.
module svng_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  svng_pkg::norm_req_t  req_i,
  output svng_pkg::norm_rsp_t  rsp_o
);
  import svng_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DIVI  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [2:0]                neg_q, neg_d;
  logic [2:0][MAG_W-1:0]     mag_q, mag_d;
  logic [1:0]                idx_q, idx_d;
  logic [3:0]                cnt_q, cnt_d;
  logic [59:0]               prod_q, prod_d;
  logic [63:0]               acc_q, acc_d;
  logic [63:0]               root_q, root_d;
  logic [63:0]               bit_q, bit_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [LEN_W-1:0]          rem_q, rem_d;
  logic [QUO_W-1:0]          nlo_q, nlo_d;
  logic [QUO_W-1:0]          quo_q, quo_d;
  logic [2:0][NRM_W-1:0]     nrm_q, nrm_d;

  logic [MAG_W-1:0]          mor;
  logic [63:0]               trial;
  logic [44:0]               numer;
  logic [LEN_W:0]            rem2;
  logic                      qbit;
  logic [QUO_W-1:0]          quo_n;

  always_comb begin
    mor   = mag_q[0] | mag_q[1] | mag_q[2];
    trial = root_q + bit_q;
    numer = {mag_q[idx_q][29:0], {FRAC_W{1'b0}}} + 45'(len_q >> 1);
    rem2  = {rem_q, nlo_q[QUO_W-1]};
    qbit  = (rem2 >= {1'b0, len_q});
    quo_n = {quo_q[QUO_W-2:0], qbit};

    state_d = state_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    root_d  = root_q;
    bit_d   = bit_q;
    len_d   = len_q;
    rem_d   = rem_q;
    nlo_d   = nlo_q;
    quo_d   = quo_q;
    nrm_d   = nrm_q;

    case (state_q)
      N_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.neg;
          mag_d = req_i.mag;
          if ((req_i.mag[0] | req_i.mag[1] | req_i.mag[2]) == '0) begin
            nrm_d   = '0;
            state_d = N_DONE;
          end else begin
            state_d = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        if (mor[MAG_W-1:30] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!mor[29]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          idx_d   = 2'd0;
          acc_d   = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (idx_q != 2'd3) begin
          prod_d = mag_q[idx_q][29:0] * mag_q[idx_q][29:0];
        end
        if (idx_q != 2'd0) begin
          acc_d = acc_q + 64'(prod_q);
        end
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          root_d  = '0;
          bit_d   = 64'd1 << 62;
          state_d = N_SQRT;
        end
      end
      N_SQRT: begin
        if (acc_q >= trial) begin
          acc_d  = acc_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          len_d   = root_d[LEN_W-1:0];
          idx_d   = 2'd0;
          state_d = N_DIVI;
        end
      end
      N_DIVI: begin
        rem_d   = LEN_W'(numer[44:QUO_W]);
        nlo_d   = numer[QUO_W-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = N_DIV;
      end
      N_DIV: begin
        rem_d = qbit ? LEN_W'(rem2 - {1'b0, len_q}) : LEN_W'(rem2);
        nlo_d = nlo_q << 1;
        quo_d = quo_n;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(QUO_W - 1)) begin
          nrm_d[idx_q] = neg_q[idx_q] ? (~quo_n + 16'd1) : quo_n;
          idx_d        = idx_q + 2'd1;
          state_d      = (idx_q == 2'd2) ? N_DONE : N_DIVI;
        end
      end
      N_DONE: begin
        state_d = N_IDLE;
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    nlo_q  <= nlo_d;
    quo_q  <= quo_d;
    nrm_q  <= nrm_d;
  end

  assign rsp_o.done = (state_q == N_DONE);
  assign rsp_o.nrm  = nrm_q;

endmodule

/* design/smooth_vertex_normal_generator.sv */
// Smooth vertex normal generator top level: sequencer, stores and cross product.
// One request at a time. A load and an error go straight to the output stage. A read
// and a triangle both run the shared normalizer, with its range shift, 32-step square
// root and three 16-step divides; a triangle adds three position reads, the edge range
// shift, six products on one multiplier and three accumulator read-modify-writes. A
// zero vector skips the normalizer's square root and divides. The input is ready again
// only once the result has been placed in the output register, so a held output
// delays the next request.
// Stores need no clearing pass; a load zeros its vertex's accumulator.
module smooth_vertex_normal_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  svng_in_if.sink   in_i,
  svng_out_if.source out_o
);
  import svng_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD_A   = 4'd1;
  localparam logic [3:0] ST_RD_B   = 4'd2;
  localparam logic [3:0] ST_RD_C   = 4'd3;
  localparam logic [3:0] ST_CAP    = 4'd4;
  localparam logic [3:0] ST_EDGE   = 4'd5;
  localparam logic [3:0] ST_ESCL   = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_NGO    = 4'd8;
  localparam logic [3:0] ST_NWAIT  = 4'd9;
  localparam logic [3:0] ST_ACC_RD = 4'd10;
  localparam logic [3:0] ST_ACC_WR = 4'd11;
  localparam logic [3:0] ST_RD_SUM = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;

  logic [3:0]                state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [1:0]                op_q;
  logic [AW-1:0]             slot_q;
  logic [2:0][AW-1:0]        corner_q;
  logic [3*POS_W-1:0]        pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic [5:0][EDG_W-1:0]     emag_q, emag_d;
  logic [5:0]                eneg_q, eneg_d;
  logic [2:0]                step_q, step_d;
  logic [1:0]                k_q, k_d;
  logic signed [61:0]        prod_q, prod_d;
  logic [2:0][MAG_W-1:0]     cr_q, cr_d;
  logic                      res_status_q, res_status_d;
  logic [2:0][NRM_W-1:0]     res_nrm_q, res_nrm_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_status_q;
  logic [2:0][NRM_W-1:0]     out_nrm_q;

  logic                      accept;
  logic                      pos_we;
  logic [AW-1:0]             pos_raddr;
  logic [3*POS_W-1:0]        pos_rdata;
  logic                      sum_we;
  logic [AW-1:0]             sum_waddr;
  logic [3*SUM_W-1:0]        sum_wdata;
  logic [AW-1:0]             sum_raddr;
  logic [3*SUM_W-1:0]        sum_rdata;
  logic [EDG_W-1:0]          emor;
  logic [5:0][30:0]          es;
  logic [30:0]               mul_a, mul_b;
  logic                      out_free;
  norm_req_t                 nreq;
  norm_rsp_t                 nrsp;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign pos_we     = accept && (in_i.opcode == OP_LOAD);

  svng_ram #(.DW(3*POS_W), .AW(AW)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(in_i.vertex_slot),
    .wdata_i({in_i.pos_z, in_i.pos_y, in_i.pos_x}),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  svng_ram #(.DW(3*SUM_W), .AW(AW)) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .raddr_i(sum_raddr),
    .rdata_o(sum_rdata)
  );

  svng_norm u_norm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (nreq),
    .rsp_o (nrsp)
  );

  always_comb begin
    emor = '0;
    for (int i = 0; i < 6; i++) begin
      emor  = emor | emag_q[i];
      es[i] = eneg_q[i] ? (~emag_q[i][30:0] + 31'd1) : emag_q[i][30:0];
    end
    case (step_q)
      3'd0:    begin mul_a = es[1]; mul_b = es[5]; end
      3'd1:    begin mul_a = es[2]; mul_b = es[4]; end
      3'd2:    begin mul_a = es[2]; mul_b = es[3]; end
      3'd3:    begin mul_a = es[0]; mul_b = es[5]; end
      3'd4:    begin mul_a = es[0]; mul_b = es[4]; end
      default: begin mul_a = es[1]; mul_b = es[3]; end
    endcase
  end

  always_comb begin
    logic signed [EDG_W-1:0] ed;
    logic signed [MAG_W-1:0] crs;
    logic [SUM_W-1:0]        sv;
    logic [1:0]              ci;

    ed           = '0;
    crs          = '0;
    sv           = '0;
    ci           = '0;
    state_d      = state_q;
    count_d      = count_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    pc_d         = pc_q;
    emag_d       = emag_q;
    eneg_d       = eneg_q;
    step_d       = step_q;
    k_d          = k_q;
    prod_d       = prod_q;
    cr_d         = cr_q;
    res_status_d = res_status_q;
    res_nrm_d    = res_nrm_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    pos_raddr    = corner_q[0];
    sum_raddr    = corner_q[k_q];
    sum_we       = 1'b0;
    sum_waddr    = corner_q[k_q];
    sum_wdata    = '0;
    nreq         = '0;

    case (state_q)
      ST_IDLE: begin
        sum_waddr = in_i.vertex_slot;
        if (accept) begin
          res_status_d = STAT_OK;
          res_nrm_d    = '0;
          state_d      = ST_OUT;
          case (in_i.opcode)
            OP_LOAD: begin
              sum_we = 1'b1;
              if ({1'b0, in_i.vertex_slot} >= count_q) begin
                count_d = {1'b0, in_i.vertex_slot} + CW'(1);
              end
            end
            OP_TRI: begin
              if ({1'b0, in_i.corner_a} >= count_q || {1'b0, in_i.corner_b} >= count_q ||
                  {1'b0, in_i.corner_c} >= count_q) begin
                res_status_d = STAT_ERR;
              end else begin
                state_d = ST_RD_A;
              end
            end
            OP_READ: begin
              if ({1'b0, in_i.vertex_slot} >= count_q) begin
                res_status_d = STAT_ERR;
              end else begin
                state_d = ST_RD_SUM;
              end
            end
            default: begin
              res_status_d = STAT_ERR;
            end
          endcase
        end
      end
      ST_RD_A: begin
        pos_raddr = corner_q[0];
        state_d   = ST_RD_B;
      end
      ST_RD_B: begin
        pos_raddr = corner_q[1];
        pa_d      = pos_rdata;
        state_d   = ST_RD_C;
      end
      ST_RD_C: begin
        pos_raddr = corner_q[2];
        pb_d      = pos_rdata;
        state_d   = ST_CAP;
      end
      ST_CAP: begin
        pc_d    = pos_rdata;
        state_d = ST_EDGE;
      end
      ST_EDGE: begin
        for (int i = 0; i < 6; i++) begin
          ed = $signed({(i < 3 ? pb_q[(i%3)*POS_W+POS_W-1] : pc_q[(i%3)*POS_W+POS_W-1]),
                        (i < 3 ? pb_q[(i%3)*POS_W +: POS_W] : pc_q[(i%3)*POS_W +: POS_W])})
             - $signed({pa_q[(i%3)*POS_W+POS_W-1], pa_q[(i%3)*POS_W +: POS_W]});
          eneg_d[i] = ed[EDG_W-1];
          emag_d[i] = ed[EDG_W-1] ? (~ed + EDG_W'(1)) : ed;
        end
        state_d = ST_ESCL;
      end
      ST_ESCL: begin
        if (emor[EDG_W-1:30] != '0) begin
          for (int i = 0; i < 6; i++) emag_d[i] = emag_q[i] >> 1;
        end else begin
          step_d  = '0;
          cr_d    = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_q != 3'd6) begin
          prod_d = $signed(mul_a) * $signed(mul_b);
        end
        if (step_q != 3'd0) begin
          ci = 2'((step_q - 3'd1) >> 1);
          if (step_q[0]) begin
            cr_d[ci] = cr_q[ci] + MAG_W'(prod_q);
          end else begin
            cr_d[ci] = cr_q[ci] - MAG_W'(prod_q);
          end
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          state_d = ST_NGO;
        end
      end
      ST_NGO: begin
        nreq.start = 1'b1;
        for (int i = 0; i < 3; i++) begin
          crs          = $signed(cr_q[i]);
          nreq.neg[i]  = crs[MAG_W-1];
          nreq.mag[i]  = crs[MAG_W-1] ? (~cr_q[i] + MAG_W'(1)) : cr_q[i];
        end
        state_d = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (nrsp.done) begin
          if (op_q == OP_TRI) begin
            cr_d[0] = MAG_W'(nrsp.nrm[0]);
            cr_d[1] = MAG_W'(nrsp.nrm[1]);
            cr_d[2] = MAG_W'(nrsp.nrm[2]);
            k_d     = 2'd0;
            state_d = ST_ACC_RD;
          end else begin
            res_nrm_d = nrsp.nrm;
            state_d   = ST_OUT;
          end
        end
      end
      ST_ACC_RD: begin
        state_d = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        sum_we = 1'b1;
        for (int i = 0; i < 3; i++) begin
          sv = sat_add(sum_rdata[i*SUM_W +: SUM_W], cr_q[i][NRM_W-1:0]);
          sum_wdata[i*SUM_W +: SUM_W] = sv;
        end
        k_d     = k_q + 2'd1;
        state_d = (k_q == 2'd2) ? ST_OUT : ST_ACC_RD;
      end
      ST_RD_SUM: begin
        sum_raddr = slot_q;
        state_d   = ST_NGO;
        step_d    = 3'd7;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (state_q == ST_NGO && op_q == OP_READ) begin
      for (int i = 0; i < 3; i++) begin
        sv          = sum_rdata[i*SUM_W +: SUM_W];
        nreq.neg[i] = sv[SUM_W-1];
        sv          = sv[SUM_W-1] ? (~sv + SUM_W'(1)) : sv;
        nreq.mag[i] = MAG_W'(sv);
      end
    end
    if (state_q == ST_RD_SUM) begin
      sum_raddr = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_i.opcode;
      slot_q      <= in_i.vertex_slot;
      corner_q[0] <= in_i.corner_a;
      corner_q[1] <= in_i.corner_b;
      corner_q[2] <= in_i.corner_c;
    end
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    pc_q         <= pc_d;
    emag_q       <= emag_d;
    eneg_q       <= eneg_d;
    prod_q       <= prod_d;
    cr_q         <= cr_d;
    res_status_q <= res_status_d;
    res_nrm_q    <= res_nrm_d;
    if (state_q == ST_OUT && out_free) begin
      out_status_q <= res_status_q;
      out_nrm_q    <= res_nrm_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.norm_x = out_nrm_q[0];
  assign out_o.norm_y = out_nrm_q[1];
  assign out_o.norm_z = out_nrm_q[2];

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("loaded vertex count decreased");

  a_norm_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrsp.done |-> (state_q == ST_NWAIT))
    else $error("normalizer finished outside its wait state");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> out_valid_q)
    else $error("result not presented after completion");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("request taken while previous one in flight");

endmodule
